@@ design/gdh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gdh_pkg;

    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_BITS  = COORD_BITS;
    localparam int H_BITS     = DIFF_BITS + FRAC_BITS + 2;
    localparam int Q_BITS     = H_BITS;
    localparam int REM_BITS   = Q_BITS + 2;
    localparam int RAD_BITS   = 2 * Q_BITS;
    localparam int SUMSQ_BITS = 2 * DIFF_BITS + 2;
    localparam int RAD_SHIFT  = 2 * FRAC_BITS + 2;
    localparam int OCT_BITS   = DIFF_BITS + 32;

    localparam int TIE_BITS   = 18;
    localparam int TIE_FRAC   = 16;
    localparam int OUT_BITS   = 40;
    localparam int P_BITS     = H_BITS + TIE_BITS;
    localparam int RND_BITS   = (P_BITS - TIE_FRAC + 1 > OUT_BITS + 1) ?
                                (P_BITS - TIE_FRAC + 1) : (OUT_BITS + 1);

    localparam logic [30:0]         SQRT3_Q30 = 31'd1859775393;
    localparam logic [30:0]         SQRT2_Q30 = 31'd1518500250;
    localparam logic [TIE_BITS-1:0] TIE_RESET = TIE_BITS'(1) << TIE_FRAC;

    typedef enum logic [1:0] {
        FUNC_OCTILE    = 2'd0,
        FUNC_MANHATTAN = 2'd1,
        FUNC_EUCLID    = 2'd2,
        FUNC_INVALID   = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [H_BITS-1:0] h_alt;
    } t_side;

    typedef struct packed {
        logic                valid;
        t_side               side;
        logic [RAD_BITS-1:0] rad;
        logic [REM_BITS-1:0] rem;
        logic [Q_BITS-1:0]   q;
    } t_cell;

endpackage

`default_nettype wire

@@ design/gdh_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface gdh_req_if;
    import gdh_pkg::*;

    logic                         valid;
    logic                         ready;
    t_func                        func;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;

    modport source (
        output valid, func, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, func, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

interface gdh_rsp_if;
    import gdh_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] cost_estimate;
    logic                bad_kind;

    modport source (output valid, cost_estimate, bad_kind, input ready);
    modport sink (input valid, cost_estimate, bad_kind, output ready);
endinterface

interface gdh_cfg_if;
    import gdh_pkg::*;

    logic                valid;
    logic                ready;
    logic [TIE_BITS-1:0] tie_breaker;

    modport source (output valid, tie_breaker, input ready);
    modport sink (input valid, tie_breaker, output ready);
endinterface

`default_nettype wire

@@ design/grid_distance_heuristic_3d.sv @@
// Channel   Direction  Payload                                        Transfer
// i_req     in         func, first_x/y/z, second_x/y/z                valid & ready
// o_rsp     out        cost_estimate, bad_kind                        valid & ready
// i_cfg     in         tie_breaker                                    valid & ready
//
// One estimate per cycle while i_req.ready is high; each result passes through the front stages,
// then the chain of square-root cells, one result bit each, then the scaler.
// Reset is synchronous and active low; tie_breaker resets to 1.0 and i_cfg is always ready.
// A result waiting on o_rsp is held in the output register; a skid register takes one more,
// and only then does i_req.ready drop and the whole pipeline hold.
`timescale 1ns / 1ps
`default_nettype none

module grid_distance_heuristic_3d (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gdh_req_if.sink   i_req,
    gdh_rsp_if.source o_rsp,
    gdh_cfg_if.sink   i_cfg
);
    import gdh_pkg::*;

    logic                w_en;
    logic [TIE_BITS-1:0] r_tie;
    t_cell               w_chain [Q_BITS:0];

    assign i_req.ready = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tie <= TIE_RESET;
        end else if (i_cfg.valid) begin
            r_tie <= i_cfg.tie_breaker;
        end
    end

    gdh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_req.valid),
        .i_func     (i_req.func),
        .i_first_x  (i_req.first_x),
        .i_first_y  (i_req.first_y),
        .i_first_z  (i_req.first_z),
        .i_second_x (i_req.second_x),
        .i_second_y (i_req.second_y),
        .i_second_z (i_req.second_z),
        .o_head     (w_chain[0])
    );

    for (genvar g = 0; g < Q_BITS; g++) begin : g_cell
        gdh_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    gdh_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tail  (w_chain[Q_BITS]),
        .i_tie   (r_tie),
        .o_en    (w_en),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

@@ design/gdh_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gdh_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire gdh_pkg::t_func                       i_func,
    input  wire logic signed [gdh_pkg::COORD_BITS-1:0] i_first_x,
    input  wire logic signed [gdh_pkg::COORD_BITS-1:0] i_first_y,
    input  wire logic signed [gdh_pkg::COORD_BITS-1:0] i_first_z,
    input  wire logic signed [gdh_pkg::COORD_BITS-1:0] i_second_x,
    input  wire logic signed [gdh_pkg::COORD_BITS-1:0] i_second_y,
    input  wire logic signed [gdh_pkg::COORD_BITS-1:0] i_second_z,
    output gdh_pkg::t_cell                            o_head
);
    import gdh_pkg::*;

    localparam logic [OCT_BITS-1:0] OCT_RND = OCT_BITS'(1) << (29 - FRAC_BITS);

    function automatic logic [DIFF_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[COORD_BITS] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
    endfunction

    logic [2:0]                r_vld;

    t_func                     r_s1_func;
    logic [DIFF_BITS-1:0]      r_dx, r_dy, r_dz;

    logic [DIFF_BITS-1:0]      srt_a, srt_b, srt_c, srt_t;
    t_func                     r_s2_func;
    logic [DIFF_BITS-1:0]      r_lo, r_d_mid, r_d_hi;
    logic [2*DIFF_BITS-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [DIFF_BITS+1:0]      r_man;

    t_func                     r_s3_func;
    logic [DIFF_BITS+30:0]     r_p3, r_p2;
    logic [DIFF_BITS-1:0]      r_s3_d_hi;
    logic [SUMSQ_BITS-1:0]     r_sumsq;
    logic [DIFF_BITS+1:0]      r_s3_man;

    logic [OCT_BITS-1:0]       oct_sum;
    t_cell                     n_head, r_head;

    always_comb begin
        srt_t = '0;
        srt_a = r_dx;
        srt_b = r_dy;
        srt_c = r_dz;
        if (srt_a > srt_b) begin
            srt_t = srt_a; srt_a = srt_b; srt_b = srt_t;
        end
        if (srt_b > srt_c) begin
            srt_t = srt_b; srt_b = srt_c; srt_c = srt_t;
        end
        if (srt_a > srt_b) begin
            srt_t = srt_a; srt_a = srt_b; srt_b = srt_t;
        end
    end

    always_comb begin
        oct_sum = OCT_BITS'(r_p3) + OCT_BITS'(r_p2) + (OCT_BITS'(r_s3_d_hi) << 30) + OCT_RND;
        n_head.valid     = r_vld[2];
        n_head.side.func = r_s3_func;
        unique case (r_s3_func)
            FUNC_OCTILE:    n_head.side.h_alt = oct_sum[30-FRAC_BITS +: H_BITS];
            FUNC_MANHATTAN: n_head.side.h_alt = H_BITS'(r_s3_man) << FRAC_BITS;
            default:        n_head.side.h_alt = '0;
        endcase
        n_head.rad = {r_sumsq, {RAD_SHIFT{1'b0}}};
        n_head.rem = '0;
        n_head.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_head.valid <= 1'b0;
        end else if (i_en) begin
            r_vld  <= {r_vld[1:0], i_valid};
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_func <= i_func;
            r_dx      <= abs_diff(i_first_x, i_second_x);
            r_dy      <= abs_diff(i_first_y, i_second_y);
            r_dz      <= abs_diff(i_first_z, i_second_z);

            r_s2_func <= r_s1_func;
            r_lo      <= srt_a;
            r_d_mid   <= srt_b - srt_a;
            r_d_hi    <= srt_c - srt_b;
            r_sq_x    <= (2*DIFF_BITS)'(r_dx) * (2*DIFF_BITS)'(r_dx);
            r_sq_y    <= (2*DIFF_BITS)'(r_dy) * (2*DIFF_BITS)'(r_dy);
            r_sq_z    <= (2*DIFF_BITS)'(r_dz) * (2*DIFF_BITS)'(r_dz);
            r_man     <= (DIFF_BITS+2)'(r_dx) + (DIFF_BITS+2)'(r_dy) + (DIFF_BITS+2)'(r_dz);

            r_s3_func <= r_s2_func;
            r_p3      <= (DIFF_BITS+31)'(r_lo) * (DIFF_BITS+31)'(SQRT3_Q30);
            r_p2      <= (DIFF_BITS+31)'(r_d_mid) * (DIFF_BITS+31)'(SQRT2_Q30);
            r_s3_d_hi <= r_d_hi;
            r_sumsq   <= SUMSQ_BITS'(r_sq_x) + SUMSQ_BITS'(r_sq_y) + SUMSQ_BITS'(r_sq_z);
            r_s3_man  <= r_man;
        end
    end

    assign o_head = r_head;

endmodule

`default_nettype wire

@@ design/gdh_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gdh_sqrt_cell (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire gdh_pkg::t_cell i_cell,
    output gdh_pkg::t_cell o_cell
);
    import gdh_pkg::*;

    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                take;
    t_cell               n_cell, r_cell;

    // One restoring square-root step: bring down the next bit pair of the radicand.
    always_comb begin
        rem_sh = {i_cell.rem[REM_BITS-3:0], i_cell.rad[RAD_BITS-1 -: 2]};
        trial  = {i_cell.q, 2'b01};
        take   = (rem_sh >= trial);
        n_cell.valid = i_cell.valid;
        n_cell.side  = i_cell.side;
        n_cell.rad   = i_cell.rad << 2;
        n_cell.rem   = take ? (rem_sh - trial) : rem_sh;
        n_cell.q     = {i_cell.q[Q_BITS-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

@@ design/gdh_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gdh_scale (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire gdh_pkg::t_cell              i_tail,
    input  wire logic [gdh_pkg::TIE_BITS-1:0] i_tie,
    output logic                             o_en,
    gdh_rsp_if.source                        o_rsp
);
    import gdh_pkg::*;

    typedef struct packed {
        logic [OUT_BITS-1:0] cost;
        logic                bad;
    } t_res;

    logic [Q_BITS:0]     q_inc;
    logic [H_BITS-1:0]   h_sel;
    logic                r_mul_valid;
    logic                r_mul_bad;
    logic [P_BITS-1:0]   r_mul_prod;
    logic [RND_BITS-1:0] rnd;
    t_res                n_res;
    logic                r_out_valid;
    logic                r_skid_valid;
    t_res                r_out, r_skid;
    logic                out_free;

    assign o_en     = !r_skid_valid;
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        q_inc = {1'b0, i_tail.q} + (Q_BITS+1)'(1);
        h_sel = (i_tail.side.func == FUNC_EUCLID) ? q_inc[Q_BITS:1] : i_tail.side.h_alt;
    end

    always_comb begin
        rnd = RND_BITS'(r_mul_prod >> TIE_FRAC) + RND_BITS'(r_mul_prod[TIE_FRAC-1]);
        n_res.bad = r_mul_bad;
        if (r_mul_bad) begin
            n_res.cost = '0;
        end else if (|rnd[RND_BITS-1:OUT_BITS]) begin
            n_res.cost = '1;
        end else begin
            n_res.cost = rnd[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (o_en) begin
                r_mul_valid <= i_tail.valid;
            end
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= r_mul_valid;
                end
            end else if (r_mul_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_mul_bad  <= (i_tail.side.func == FUNC_INVALID);
            r_mul_prod <= P_BITS'(h_sel) * P_BITS'(i_tie);
            r_skid     <= n_res;
        end
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.cost_estimate = r_out.cost;
    assign o_rsp.bad_kind      = r_out.bad;

endmodule

`default_nettype wire

@@ design/gdh_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gdh_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_req_valid,
    input wire logic                         i_req_ready,
    input wire logic                         i_rsp_valid,
    input wire logic                         i_rsp_ready,
    input wire logic [gdh_pkg::OUT_BITS-1:0] i_rsp_cost,
    input wire logic                         i_rsp_bad
);
    import gdh_pkg::*;

    logic [7:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 8'(i_req_valid && i_req_ready)
                                   - 8'(i_rsp_valid && i_rsp_ready);
        end
    end

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_bad |-> i_rsp_cost == '0)
        else $error("bad_kind result with nonzero cost");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_cost)
                                        && $stable(i_rsp_bad))
        else $error("stalled result changed");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pending != 8'd0)
        else $error("result without an accepted input");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid)
        else $error("input stalled with no result waiting");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && i_req_ready)
        else $error("outputs not cleared by reset");

endmodule

bind grid_distance_heuristic_3d gdh_checker u_gdh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_cost  (o_rsp.cost_estimate),
    .i_rsp_bad   (o_rsp.bad_kind)
);

`default_nettype wire

@@ tb/tb_grid_distance_heuristic_3d.sv @@
`timescale 1ns / 1ps

module tb_grid_distance_heuristic_3d;
    import gdh_pkg::*;

    typedef struct {
        t_func                        func;
        logic signed [COORD_BITS-1:0] p[3];
        logic signed [COORD_BITS-1:0] q[3];
    } t_cell_pair;

    typedef struct {
        logic [OUT_BITS-1:0] cost;
        logic                bad;
    } t_cost;

    localparam logic [63:0]  ROOT3   = 64'(SQRT3_Q30);
    localparam logic [63:0]  ROOT2   = 64'(SQRT2_Q30);
    localparam logic [127:0] OUT_TOP = 128'({OUT_BITS{1'b1}});
    localparam int           RAND_PER_PHASE = 92;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gdh_req_if req_if ();
    gdh_rsp_if rsp_if ();
    gdh_cfg_if cfg_if ();

    grid_distance_heuristic_3d i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    t_cell_pair          pending_cells[$];
    t_cost               expected_costs[$];
    t_cell_pair          on_wire;
    logic [TIE_BITS-1:0] tie_now;
    bit                  req_done;
    bit                  send_quiet;
    bit                  recv_quiet;
    int unsigned         send_gap;
    int unsigned         recv_stall;
    int                  mismatch_count;
    int                  results_checked;
    int                  kind_count[4];
    int                  tie_settings;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned draw_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COORD_BITS-1:0] axis_gap(logic signed [COORD_BITS-1:0] a,
                                                       logic signed [COORD_BITS-1:0] b);
        logic signed [COORD_BITS:0] d;
        d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
        if (d[COORD_BITS]) begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

    function automatic logic [63:0] octile_q16(logic [COORD_BITS-1:0] a,
                                               logic [COORD_BITS-1:0] b,
                                               logic [COORD_BITS-1:0] c);
        logic [COORD_BITS-1:0] t;
        logic [63:0]           acc;
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        acc = ROOT3 * 64'(a) + ROOT2 * (64'(b) - 64'(a)) + ((64'(c) - 64'(b)) << 30);
        return (acc + (64'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    function automatic logic [63:0] euclid_q16(logic [COORD_BITS-1:0] a,
                                               logic [COORD_BITS-1:0] b,
                                               logic [COORD_BITS-1:0] c);
        logic [127:0] rad;
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        int           i;
        rad  = (128'(a) * 128'(a) + 128'(b) * 128'(b) + 128'(c) * 128'(c))
               << (2 * FRAC_BITS + 2);
        rem  = '0;
        root = '0;
        for (i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 128'd1;
            end else begin
                root = root << 1;
            end
        end
        return 64'((root + 128'd1) >> 1);
    endfunction

    function automatic logic [OUT_BITS-1:0] scale_cost(logic [63:0] h,
                                                       logic [TIE_BITS-1:0] tie);
        logic [127:0] p;
        logic [127:0] r;
        p = 128'(h) * 128'(tie);
        r = (p >> TIE_FRAC) + 128'(p[TIE_FRAC-1]);
        return (r > OUT_TOP) ? {OUT_BITS{1'b1}} : r[OUT_BITS-1:0];
    endfunction

    function automatic t_cost predict_cost(t_cell_pair c, logic [TIE_BITS-1:0] tie);
        logic [COORD_BITS-1:0] d[3];
        logic [63:0]           h;
        t_cost                 r;
        int                    k;
        for (k = 0; k < 3; k++) begin
            d[k] = axis_gap(c.p[k], c.q[k]);
        end
        r.bad = 1'b0;
        case (c.func)
            FUNC_OCTILE: begin
                h = octile_q16(d[0], d[1], d[2]);
            end
            FUNC_MANHATTAN: begin
                h = (64'(d[0]) + 64'(d[1]) + 64'(d[2])) << FRAC_BITS;
            end
            FUNC_EUCLID: begin
                h = euclid_q16(d[0], d[1], d[2]);
            end
            default: begin
                h     = '0;
                r.bad = 1'b1;
            end
        endcase
        r.cost = r.bad ? '0 : scale_cost(h, tie);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic add_pair(t_func f, int x0, int y0, int z0, int x1, int y1, int z1);
        t_cell_pair c;
        c.func = f;
        c.p[0] = COORD_BITS'(x0);
        c.p[1] = COORD_BITS'(y0);
        c.p[2] = COORD_BITS'(z0);
        c.q[0] = COORD_BITS'(x1);
        c.q[1] = COORD_BITS'(y1);
        c.q[2] = COORD_BITS'(z1);
        pending_cells.push_back(c);
    endtask

    task automatic write_tie(logic [TIE_BITS-1:0] v);
        @(negedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.tie_breaker <= v;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        tie_now = v;
        tie_settings++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_cells.size() != 0 || req_if.valid || expected_costs.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            req_done = 1'b1;
            expected_costs.push_back(predict_cost(on_wire, tie_now));
            kind_count[int'(on_wire.func)]++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_done) begin
            req_done = 1'b0;
            if ($urandom_range(0, 249) == 0) begin
                send_quiet = !send_quiet;
            end
            if (send_gap > 0) begin
                send_gap--;
                req_if.valid <= 1'b0;
            end else if (pending_cells.size() > 0) begin
                on_wire = pending_cells.pop_front();
                req_if.valid    <= 1'b1;
                req_if.func     <= on_wire.func;
                req_if.first_x  <= on_wire.p[0];
                req_if.first_y  <= on_wire.p[1];
                req_if.first_z  <= on_wire.p[2];
                req_if.second_x <= on_wire.q[0];
                req_if.second_y <= on_wire.q[1];
                req_if.second_z <= on_wire.q[2];
                send_gap = send_quiet ? 0 : draw_idle_len();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 249) == 0) begin
            recv_quiet = !recv_quiet;
        end
        if (recv_stall > 0) begin
            recv_stall--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if (!recv_quiet && $urandom_range(0, 3) == 0) begin
                recv_stall = draw_idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_cost want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_costs.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing outstanding, cost %0d",
                                          rsp_if.cost_estimate));
            end else begin
                want = expected_costs.pop_front();
                if (rsp_if.cost_estimate !== want.cost) begin
                    report_mismatch($sformatf("result %0d: cost_estimate %0d, predicted %0d",
                                              results_checked, rsp_if.cost_estimate,
                                              want.cost));
                end
                if (rsp_if.bad_kind !== want.bad) begin
                    report_mismatch($sformatf("result %0d: bad_kind %0b, predicted %0b",
                                              results_checked, rsp_if.bad_kind, want.bad));
                end
            end
            results_checked++;
        end
    end

    initial begin
        #6_000_000;
        $display("Timed out with %0d results still outstanding.", expected_costs.size());
        $display("grid_distance_heuristic_3d: mismatch");
        $finish;
    end

    initial begin
        logic [TIE_BITS-1:0] tie_plan[6];
        t_cell_pair          cp;
        int                  corner[5];
        int                  ph;
        int                  n;
        int                  k;
        int                  sel;
        int                  r;
        int                  base;
        int                  spread;

        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.func        = FUNC_OCTILE;
        req_if.first_x     = '0;
        req_if.first_y     = '0;
        req_if.first_z     = '0;
        req_if.second_x    = '0;
        req_if.second_y    = '0;
        req_if.second_z    = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.tie_breaker = TIE_RESET;
        tie_now            = TIE_RESET;
        req_done           = 1'b0;
        send_quiet         = 1'b0;
        recv_quiet         = 1'b0;
        send_gap           = 0;
        recv_stall         = 0;
        mismatch_count     = 0;
        results_checked    = 0;
        tie_settings       = 0;
        kind_count         = '{0, 0, 0, 0};
        corner             = '{-524288, 524287, 0, -1, 1};
        tie_plan = '{18'h3FFFF, 18'd0, 18'd1, 18'($urandom_range(2, 262140)),
                     18'd32768, TIE_RESET};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_pair(FUNC_OCTILE, 0, 0, 0, 0, 0, 0);
        add_pair(FUNC_MANHATTAN, 5, -7, 9, 5, -7, 9);
        add_pair(FUNC_EUCLID, -524288, -524288, -524288, -524288, -524288, -524288);
        add_pair(FUNC_INVALID, 0, 0, 0, 0, 0, 0);
        add_pair(FUNC_OCTILE, -524288, -524288, -524288, 524287, 524287, 524287);
        add_pair(FUNC_MANHATTAN, -524288, -524288, -524288, 524287, 524287, 524287);
        add_pair(FUNC_EUCLID, -524288, -524288, -524288, 524287, 524287, 524287);
        add_pair(FUNC_INVALID, -524288, -524288, -524288, 524287, 524287, 524287);
        add_pair(FUNC_OCTILE, 524287, 524287, 524287, -524288, -524288, -524288);
        add_pair(FUNC_OCTILE, 0, 0, 0, 3, 7, 11);
        add_pair(FUNC_OCTILE, 0, 0, 0, 11, -3, 7);
        add_pair(FUNC_OCTILE, 0, 0, 0, 5, 5, 5);
        add_pair(FUNC_OCTILE, 0, 0, 0, 0, 0, 9);
        add_pair(FUNC_EUCLID, 0, 0, 0, 3, 4, 0);
        add_pair(FUNC_EUCLID, 1, 1, 1, 0, 0, 0);
        add_pair(FUNC_EUCLID, -1, 2, -3, 524287, -524288, 100);
        add_pair(FUNC_MANHATTAN, -524288, 524287, -1, 524287, -524288, 0);
        add_pair(FUNC_INVALID, 123, -456, 789, -1, 2, 3);
        add_pair(FUNC_MANHATTAN, 0, 0, 0, 1, 0, 0);
        add_pair(FUNC_EUCLID, 0, 0, 0, 0, 0, 1);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            write_tie(tie_plan[ph]);
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                sel = $urandom_range(0, 99);
                r   = $urandom_range(0, 99);
                cp.func = (r < 30) ? FUNC_OCTILE :
                          (r < 60) ? FUNC_MANHATTAN :
                          (r < 90) ? FUNC_EUCLID : FUNC_INVALID;
                spread = ($urandom_range(0, 3) == 0) ? 131072 : 1000;
                for (k = 0; k < 3; k++) begin
                    if (sel < 40) begin
                        cp.p[k] = COORD_BITS'($urandom());
                        cp.q[k] = COORD_BITS'($urandom());
                    end else if (sel < 80) begin
                        base    = int'($urandom_range(0, 524288)) - 262144;
                        cp.p[k] = COORD_BITS'(base);
                        cp.q[k] = COORD_BITS'(base + int'($urandom_range(0, 2 * spread))
                                              - spread);
                    end else begin
                        cp.p[k] = COORD_BITS'(corner[$urandom_range(0, 4)]);
                        cp.q[k] = COORD_BITS'(corner[$urandom_range(0, 4)]);
                    end
                end
                pending_cells.push_back(cp);
            end
            wait_idle();
        end

        repeat (Q_BITS + 20) @(posedge i_clk);

        $display("Checked %0d results: octile %0d, Manhattan %0d, Euclidean %0d, invalid %0d.",
                 results_checked, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("Tie-breaker: reset value plus %0d written settings incl. zero and full scale.",
                 tie_settings);
        if (mismatch_count == 0) begin
            $display("grid_distance_heuristic_3d: match");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("grid_distance_heuristic_3d: mismatch");
        end
        $finish;
    end

endmodule
